@@ rtl/core/g6r44_pkg.sv @@
`default_nettype none

package g6r44_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int EDGE_W    = 55;
    localparam int PAYLOAD_W = 60;
    localparam int COUNT_W   = 4;
    localparam int GROUP_W   = 6;

    // graph6 printable range and header offset
    localparam logic [BYTE_W-1:0]  CHAR_BASE = 8'd63;
    localparam logic [BYTE_W-1:0]  CHAR_MAX  = 8'd126;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

    // Result status, in check order
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_HEADER   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_PADDING  = 3'd4,
        ST_WIDE     = 3'd5,
        ST_MISMATCH = 3'd6,
        ST_MONO     = 3'd7
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] record_byte;
        logic              last_byte;
        logic [WORD_W-1:0] core_word;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        status;
        logic [EDGE_W-1:0] edge_word;
    } t_out_beat;

    // Row-major lexicographic index of pair (i,j), i < j, for v vertices
    function automatic int lex_idx(input int i, input int j, input int v);
        lex_idx = i * v - (i * (i + 1)) / 2 + (j - i - 1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/graph6_ramsey_four_set_checker_core.sv @@
`default_nettype none

// graph6 record checker for a VERTICES-vertex graph. One record byte is taken per
// beat, the final one flagged by last_byte and carrying the claimed 64-bit edge word.
// Each record yields one result beat: the first failing check (length, header, byte
// range, padding, word width, word mismatch, monochromatic 4-set) and the decoded
// adjacency in row-major pair order, zeroed on a length, header, range or padding
// error. A byte is accepted every cycle unless a finished record is still waiting
// behind a stalled result. The snapshot register loads on the edge that accepts the
// last byte, and the result register loads from the snapshot once the output is not
// stalled. The clock period is set by the decode, the word compare and the parallel
// check of all 4-vertex subsets between the snapshot and the result register.
module graph6_ramsey_four_set_checker_core
    import g6r44_pkg::*;
#(
    parameter int VERTICES = 11
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    localparam int EDGES         = VERTICES * (VERTICES - 1) / 2;
    localparam int PAYLOAD_BYTES = (EDGES + 5) / 6;
    localparam int RECORD_BYTES  = 1 + PAYLOAD_BYTES;
    localparam int PAD_BITS      = GROUP_W * PAYLOAD_BYTES - EDGES;
    localparam logic [BYTE_W-1:0]  HDR_BYTE  = BYTE_W'(63 + VERTICES);
    localparam logic [COUNT_W-1:0] REC_LEN   = COUNT_W'(RECORD_BYTES);
    localparam logic [COUNT_W-1:0] PAY_LAST  = COUNT_W'(PAYLOAD_BYTES);

    // Record accumulator
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [PAYLOAD_W-1:0] r_payload, n_payload;
    logic                 r_hdr_err, n_hdr_err;
    logic                 r_rng_err, n_rng_err;

    // Snapshot of a finished record
    logic                 r_a_valid;
    logic [COUNT_W-1:0]   r_a_count;
    logic [PAYLOAD_W-1:0] r_a_payload;
    logic                 r_a_hdr_err;
    logic                 r_a_rng_err;
    logic [WORD_W-1:0]    r_a_word;

    // Result register
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic                 in_acc;
    logic                 can_out;
    logic                 a_adv;
    logic [BYTE_W-1:0]    grp_byte;

    assign can_out     = !r_out_valid || !i_out_stall;
    assign a_adv       = r_a_valid && can_out;
    assign o_in_stall  = r_a_valid && !can_out;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign grp_byte    = i_in_data.record_byte - CHAR_BASE;

    // Per-byte update of the accumulator
    always_comb begin
        n_hdr_err = r_hdr_err;
        n_rng_err = r_rng_err;
        n_payload = r_payload;
        n_count   = r_count;
        if (r_count == '0 && i_in_data.record_byte != HDR_BYTE) begin
            n_hdr_err = 1'b1;
        end
        if (i_in_data.record_byte < CHAR_BASE || i_in_data.record_byte > CHAR_MAX) begin
            n_rng_err = 1'b1;
        end
        if (r_count >= 4'd1 && r_count <= PAY_LAST) begin
            n_payload = {r_payload[PAYLOAD_W-GROUP_W-1:0], grp_byte[GROUP_W-1:0]};
        end
        if (r_count < COUNT_SAT) begin
            n_count = r_count + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_payload <= '0;
            r_hdr_err <= 1'b0;
            r_rng_err <= 1'b0;
        end else if (in_acc) begin
            if (i_in_data.last_byte) begin
                r_count   <= '0;
                r_payload <= '0;
                r_hdr_err <= 1'b0;
                r_rng_err <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_payload <= n_payload;
                r_hdr_err <= n_hdr_err;
                r_rng_err <= n_rng_err;
            end
        end
    end

    // Snapshot stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            r_a_count   <= n_count;
            r_a_payload <= n_payload;
            r_a_hdr_err <= n_hdr_err;
            r_a_rng_err <= n_rng_err;
            r_a_word    <= i_in_data.core_word;
        end
    end

    // Decode column-order payload into row-major packing
    logic [EDGE_W-1:0] packed_edges;

    always_comb begin
        packed_edges = '0;
        for (int j = 1; j < VERTICES; j++) begin
            for (int i = 0; i < j; i++) begin
                packed_edges[lex_idx(i, j, VERTICES)] =
                    r_a_payload[GROUP_W * PAYLOAD_BYTES - 1 - (j * (j - 1) / 2 + i)];
            end
        end
    end

    // Padding, width and 4-set checks
    logic pad_nz;
    logic too_wide;
    logic mono;

    always_comb begin
        pad_nz = 1'b0;
        for (int b = 0; b < PAD_BITS; b++) begin
            pad_nz = pad_nz | r_a_payload[b];
        end
    end

    always_comb begin
        too_wide = 1'b0;
        for (int b = EDGES; b < WORD_W; b++) begin
            too_wide = too_wide | r_a_word[b];
        end
    end

    always_comb begin
        logic [5:0] six;
        six  = '0;
        mono = 1'b0;
        for (int a = 0; a < VERTICES; a++) begin
            for (int c = a + 1; c < VERTICES; c++) begin
                for (int d = c + 1; d < VERTICES; d++) begin
                    for (int e = d + 1; e < VERTICES; e++) begin
                        six = {packed_edges[lex_idx(a, c, VERTICES)],
                               packed_edges[lex_idx(a, d, VERTICES)],
                               packed_edges[lex_idx(a, e, VERTICES)],
                               packed_edges[lex_idx(c, d, VERTICES)],
                               packed_edges[lex_idx(c, e, VERTICES)],
                               packed_edges[lex_idx(d, e, VERTICES)]};
                        mono = mono | (six == 6'b000000) | (six == 6'b111111);
                    end
                end
            end
        end
    end

    // Status in check order
    t_status   status;
    t_out_beat n_out;

    always_comb begin
        if (r_a_count != REC_LEN) begin
            status = ST_LENGTH;
        end else if (r_a_hdr_err) begin
            status = ST_HEADER;
        end else if (r_a_rng_err) begin
            status = ST_RANGE;
        end else if (pad_nz) begin
            status = ST_PADDING;
        end else if (too_wide) begin
            status = ST_WIDE;
        end else if (r_a_word[EDGE_W-1:0] != packed_edges) begin
            status = ST_MISMATCH;
        end else if (mono) begin
            status = ST_MONO;
        end else begin
            status = ST_OK;
        end
        n_out.status = status;
        case (status) inside
            ST_LENGTH, ST_HEADER, ST_RANGE, ST_PADDING: n_out.edge_word = '0;
            default:                                    n_out.edge_word = packed_edges;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_out) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_out <= n_out;
        end
    end

    // Record end clears the accumulator
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_byte) |=> (r_count == '0 && r_payload == '0))
        else $error("accumulator not cleared after last beat");

    // Last beat lands in the snapshot stage
    a_snap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_byte) |=> r_a_valid)
        else $error("finished record lost before snapshot");

    // Advancing snapshot produces a result beat
    a_adv_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv |=> r_out_valid)
        else $error("snapshot advanced without a result");

    // Format errors report an empty edge word
    a_fmt_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_LENGTH || r_out.status == ST_HEADER ||
                         r_out.status == ST_RANGE || r_out.status == ST_PADDING))
        |-> (r_out.edge_word == '0))
        else $error("nonzero edge word on format error");

endmodule

`default_nettype wire
